FILE: src/mfd_pkg.sv
package mfd_pkg;

  localparam int FRAME_ROWS  = 256;
  localparam int ROW_BYTES   = 32;
  localparam int STORE_DEPTH = FRAME_ROWS * ROW_BYTES;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PAGE_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam int ROW_W       = 8;

  localparam logic [7:0]  COLUMN_OFFSET_RST = 8'd20;
  localparam logic [15:0] SET_COLOR_RST     = 16'h0000;
  localparam logic [15:0] CLEAR_COLOR_RST   = 16'hffff;

  localparam logic       CMD_PUT   = 1'b0;
  localparam logic       CMD_FLUSH = 1'b1;

  localparam logic [1:0] REG_COLUMN_OFFSET = 2'd0;
  localparam logic [1:0] REG_SET_COLOR     = 2'd1;
  localparam logic [1:0] REG_CLEAR_COLOR   = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic       pixel_on;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  column;
    logic [7:0]  row;
    logic [15:0] color;
    logic        last;
  } out_req_t;

  // changed byte handed to the serializer
  typedef struct packed {
    logic             load;
    logic [7:0]       pix;
    logic [ROW_W-1:0] row;
    logic [7:0]       col_base;
  } emit_load_t;

  // one memory word holds the frame byte and its sent copy
  typedef struct packed {
    logic [7:0] sent;
    logic [7:0] frame;
  } store_word_t;

endpackage

FILE: src/mfd_store.sv
module mfd_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [mfd_pkg::ADDR_W-1:0] waddr,
  input  mfd_pkg::store_word_t      wdata,
  input  logic                      re,
  input  logic [mfd_pkg::ADDR_W-1:0] raddr,
  output mfd_pkg::store_word_t      rdata
);

  mfd_pkg::store_word_t mem [mfd_pkg::STORE_DEPTH];
  mfd_pkg::store_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/mfd_emit.sv
module mfd_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  mfd_pkg::emit_load_t ld,
  input  logic [15:0]         set_color,
  input  logic [15:0]         clear_color,
  output logic                out_valid,
  input  logic                out_ready,
  output mfd_pkg::out_req_t   out_data,
  output logic                busy
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [7:0]                pix_r;
  logic [7:0]                pix_nxt;
  logic [2:0]                cnt_r;
  logic [2:0]                cnt_nxt;
  logic [mfd_pkg::ROW_W-1:0] row_r;
  logic [mfd_pkg::ROW_W-1:0] row_nxt;
  logic [7:0]                base_r;
  logic [7:0]                base_nxt;
  logic                      is_last;

  assign is_last = (cnt_r == 3'd7);

  always_comb begin
    valid_nxt = valid_r;
    pix_nxt   = pix_r;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    if (ld.load) begin
      valid_nxt = 1'b1;
      pix_nxt   = ld.pix;
      cnt_nxt   = 3'd0;
      row_nxt   = ld.row;
      base_nxt  = ld.col_base;
    end else if (valid_r && out_ready) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else begin
        pix_nxt = {pix_r[6:0], 1'b0};
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r  <= pix_nxt;
    row_r  <= row_nxt;
    base_r <= base_nxt;
  end

  assign out_valid       = valid_r;
  assign busy            = valid_r;
  assign out_data.column = base_r + {5'd0, cnt_r};
  assign out_data.row    = 8'(row_r);
  assign out_data.color  = pix_r[7] ? set_color : clear_color;
  assign out_data.last   = is_last;

endmodule

FILE: src/mono_framebuffer_diff_flush.sv
// 1-bit-per-pixel frame store with dirty-byte flush to an RGB565 panel. Frame
// bytes and their last-sent copies share one 8192 x 16 synchronous memory.
// After reset the block runs a clearing pass over all 8192 words (one word a cycle)
// and takes no request until it ends; config writes are taken throughout.
// A put-pixel request reads the byte, then modifies and writes it back; a flush
// step reads a byte and, if it changed, writes back its sent copy and hands it
// to the serializer for its eight pixel writes at one per cycle when out_ready
// stays high. One request is in flight at a time, and none is taken while the
// serializer is busy.
module mono_framebuffer_diff_flush (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mfd_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mfd_pkg::out_req_t  out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROC  = 2'd2;

  localparam logic [mfd_pkg::ADDR_W-1:0] LAST_ADDR =
    mfd_pkg::ADDR_W'(mfd_pkg::STORE_DEPTH - 1);
  localparam logic [mfd_pkg::PAGE_W-1:0] LAST_PAGE =
    mfd_pkg::PAGE_W'(mfd_pkg::ROW_BYTES - 1);
  localparam logic [mfd_pkg::ROW_W-1:0] LAST_ROW =
    mfd_pkg::ROW_W'(mfd_pkg::FRAME_ROWS - 1);

  logic [1:0]                   state_r;
  logic [1:0]                   state_nxt;
  logic [mfd_pkg::ADDR_W-1:0]   clr_addr_r;
  logic [mfd_pkg::ADDR_W-1:0]   clr_addr_nxt;
  logic [mfd_pkg::ROW_W-1:0]    scan_row_r;
  logic [mfd_pkg::ROW_W-1:0]    scan_row_nxt;
  logic [mfd_pkg::PAGE_W-1:0]   scan_page_r;
  logic [mfd_pkg::PAGE_W-1:0]   scan_page_nxt;
  logic [7:0]                   column_offset_r;
  logic [15:0]                  set_color_r;
  logic [15:0]                  clear_color_r;

  logic                         cmd_r;
  logic                         on_r;
  logic                         valid_pix_r;
  logic [2:0]                   bit_r;
  logic [mfd_pkg::ADDR_W-1:0]   addr_r;

  logic                         accept;
  logic                         emit_busy;
  logic                         in_frame;
  logic [mfd_pkg::ADDR_W-1:0]   put_addr;
  logic [mfd_pkg::ADDR_W-1:0]   scan_addr;
  logic [mfd_pkg::ADDR_W-1:0]   rd_addr;
  logic                         mem_we;
  logic [mfd_pkg::ADDR_W-1:0]   mem_waddr;
  mfd_pkg::store_word_t         mem_wdata;
  mfd_pkg::store_word_t         rd_word;
  logic [7:0]                   mask;
  mfd_pkg::emit_load_t          ld;

  assign in_ready = (state_r == S_IDLE) && !emit_busy;
  assign accept   = in_valid && in_ready;

  assign in_frame = ({1'b0, in_data.y_pos} < 9'(mfd_pkg::FRAME_ROWS)) &&
                    ({3'b000, in_data.x_pos[7:3]} < 8'(mfd_pkg::ROW_BYTES));
  assign put_addr = mfd_pkg::ADDR_W'(in_data.y_pos) *
                    mfd_pkg::ADDR_W'(mfd_pkg::ROW_BYTES) +
                    mfd_pkg::ADDR_W'(in_data.x_pos[7:3]);
  assign scan_addr = mfd_pkg::ADDR_W'(scan_row_r) *
                     mfd_pkg::ADDR_W'(mfd_pkg::ROW_BYTES) +
                     mfd_pkg::ADDR_W'(scan_page_r);
  assign rd_addr = (in_data.cmd == mfd_pkg::CMD_FLUSH) ? scan_addr : put_addr;

  assign mask = 8'h80 >> bit_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    scan_row_nxt  = scan_row_r;
    scan_page_nxt = scan_page_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = rd_word;
    ld.load       = 1'b0;
    ld.pix        = rd_word.frame;
    ld.row        = scan_row_r;
    ld.col_base   = 8'({scan_page_r, 3'b000}) + column_offset_r;
    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        state_nxt = S_IDLE;
        if (cmd_r == mfd_pkg::CMD_PUT) begin
          mem_we = valid_pix_r;
          mem_wdata.frame = on_r ? (rd_word.frame | mask) : (rd_word.frame & ~mask);
        end else begin
          if (rd_word.frame != rd_word.sent) begin
            mem_we         = 1'b1;
            mem_wdata.sent = rd_word.frame;
            ld.load        = 1'b1;
          end
          if (scan_page_r == LAST_PAGE) begin
            scan_page_nxt = '0;
            scan_row_nxt  = (scan_row_r == LAST_ROW) ? '0 : scan_row_r + 1'b1;
          end else begin
            scan_page_nxt = scan_page_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_addr_r      <= '0;
      scan_row_r      <= '0;
      scan_page_r     <= '0;
      column_offset_r <= mfd_pkg::COLUMN_OFFSET_RST;
      set_color_r     <= mfd_pkg::SET_COLOR_RST;
      clear_color_r   <= mfd_pkg::CLEAR_COLOR_RST;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_page_r <= scan_page_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mfd_pkg::REG_COLUMN_OFFSET: column_offset_r <= cfg_wdata[7:0];
          mfd_pkg::REG_SET_COLOR:     set_color_r     <= cfg_wdata;
          mfd_pkg::REG_CLEAR_COLOR:   clear_color_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_data.cmd;
      on_r        <= in_data.pixel_on;
      valid_pix_r <= in_frame;
      bit_r       <= in_data.x_pos[2:0];
      addr_r      <= rd_addr;
    end
  end

  mfd_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  mfd_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (ld),
    .set_color   (set_color_r),
    .clear_color (clear_color_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .busy        (emit_busy)
  );

endmodule
